// File: design/u8dec_pkg.sv
// ----------------------------------------------------------------------------
// u8dec_pkg
// Types and constants shared by the UTF-8 decoder modules.
// ----------------------------------------------------------------------------
package u8dec_pkg;

  localparam int unsigned SPAN_DEPTH = 4;
  localparam int unsigned FILL_W     = 3;

  localparam logic [20:0] REPLACEMENT_CP = 21'h00FFFD;

  localparam logic [7:0] LEAD2_MASK = 8'hE0;
  localparam logic [7:0] LEAD2_CODE = 8'hC0;
  localparam logic [7:0] LEAD3_MASK = 8'hF0;
  localparam logic [7:0] LEAD3_CODE = 8'hE0;
  localparam logic [7:0] LEAD4_MASK = 8'hF8;
  localparam logic [7:0] LEAD4_CODE = 8'hF0;
  localparam logic [7:0] CONT_MASK  = 8'hC0;
  localparam logic [7:0] CONT_CODE  = 8'h80;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       text_end;
  } in_item_t;

  typedef struct packed {
    logic [20:0] code_point;
    logic        final_point;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic load;   // take the accepted byte into the span buffer
    logic step;   // make one decode decision at the head of the buffer
  } u8dec_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic emit;       // the pending decision produces a result
    logic done;       // after the pending decision nothing is left to do
    logic slot_free;  // output register can take a result this cycle
  } u8dec_status_t;

endpackage

// File: design/utf8_code_point_decoder.sv
// ----------------------------------------------------------------------------
// utf8_code_point_decoder
// UTF-8 byte stream to code points, with U+FFFD for malformed input.
// ----------------------------------------------------------------------------
// Takes one text byte per item (with an end-of-text flag) and returns zero or
// more code points. Bytes are kept in a four-entry span buffer; a controller
// then makes one decode decision per cycle at the buffer head, unless a
// decision that emits waits for the output register: an ASCII byte, a bad
// lead or a complete multi-byte span each give one code point. A span
// with a bad continuation gives U+FFFD for the lead only, and the bytes after
// the lead are decoded again from the buffer, so one byte can give up to four
// results. If the text ends inside a span, one U+FFFD closes the text. The
// last result of a text carries final_point. A byte is accepted in ST_IDLE
// and decisions are then stepped in ST_RUN; input is not taken while
// decisions remain. Each result waits for the single output register, so
// out_ready low stretches the work. No overlong or surrogate checks are done.
// ----------------------------------------------------------------------------
module utf8_code_point_decoder
  import u8dec_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  u8dec_cmd_t    cmd;
  u8dec_status_t status;

  // sequencing: load, then step decisions until the buffer settles
  u8dec_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // storage and decode
  u8dec_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .status    (status),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// File: design/u8dec_ctrl.sv
// ----------------------------------------------------------------------------
// u8dec_ctrl
// Controller: accepts a byte, then steps decode decisions until the buffer
// is settled.
// ----------------------------------------------------------------------------
module u8dec_ctrl
  import u8dec_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  u8dec_status_t status,
  output u8dec_cmd_t    cmd
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    in_ready  = 1'b0;
    cmd.load  = 1'b0;
    cmd.step  = 1'b0;
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        // a decision that emits waits for the output slot
        cmd.step = status.slot_free || !status.emit;
        if (cmd.step && status.done) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: design/u8dec_dpath.sv
// ----------------------------------------------------------------------------
// u8dec_dpath
// Datapath: span buffer, fill count, head decoder and output register.
// ----------------------------------------------------------------------------
module u8dec_dpath
  import u8dec_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  u8dec_cmd_t    cmd,
  output u8dec_status_t status,
  input  in_item_t      in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output out_item_t     out_data
);

  logic [7:0]        span_r [SPAN_DEPTH];
  logic [FILL_W-1:0] fill_r;
  logic              last_r;
  logic              out_valid_r;
  out_item_t         out_item_r;

  logic [7:0]        b0;
  logic [1:0]        need;
  logic              complete;
  logic              c1, c2, c3;
  logic              cont_ok;
  logic              emit;
  logic [20:0]       cp;
  logic [FILL_W-1:0] consume;
  logic [FILL_W-1:0] fill_nxt;

  // head decode: the lead is always at entry 0
  always_comb begin
    b0   = span_r[0];
    need = 2'd0;
    if ((b0 & LEAD2_MASK) == LEAD2_CODE) begin
      need = 2'd1;
    end else if ((b0 & LEAD3_MASK) == LEAD3_CODE) begin
      need = 2'd2;
    end else if ((b0 & LEAD4_MASK) == LEAD4_CODE) begin
      need = 2'd3;
    end
    complete = fill_r > {1'b0, need};
    c1 = (span_r[1] & CONT_MASK) == CONT_CODE;
    c2 = (span_r[2] & CONT_MASK) == CONT_CODE;
    c3 = (span_r[3] & CONT_MASK) == CONT_CODE;
    cont_ok = c1 && ((need < 2'd2) || c2) && ((need < 2'd3) || c3);

    emit    = 1'b1;
    cp      = REPLACEMENT_CP;
    consume = FILL_W'(1);
    if (!b0[7]) begin
      cp = {13'd0, b0};
    end else if (need == 2'd0) begin
      cp = REPLACEMENT_CP;                         // stray continuation or 11111xxx
    end else if (complete && cont_ok) begin
      consume = FILL_W'(need) + FILL_W'(1);
      case (need)
        2'd1:    cp = {10'd0, b0[4:0], span_r[1][5:0]};
        2'd2:    cp = {5'd0, b0[3:0], span_r[1][5:0], span_r[2][5:0]};
        default: cp = {b0[2:0], span_r[1][5:0], span_r[2][5:0], span_r[3][5:0]};
      endcase
    end else if (complete) begin
      cp = REPLACEMENT_CP;                         // bad continuation: replay after lead
    end else if (last_r) begin
      consume = fill_r;                            // text ends mid-span: drop the rest
    end else begin
      emit    = 1'b0;                              // wait for more bytes
      consume = '0;
    end
    fill_nxt = fill_r - consume;
  end

  assign status.emit      = emit;
  assign status.done      = (fill_nxt == '0) || !emit;
  assign status.slot_free = !out_valid_r || out_ready;

  // span buffer: write at the fill position, consume by fixed shifts
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      span_r[fill_r[1:0]] <= in_data.text_byte;
    end else if (cmd.step) begin
      case (consume)
        FILL_W'(1): begin
          for (int i = 0; i < SPAN_DEPTH - 1; i++) span_r[i] <= span_r[i + 1];
        end
        FILL_W'(2): begin
          for (int i = 0; i < SPAN_DEPTH - 2; i++) span_r[i] <= span_r[i + 2];
        end
        FILL_W'(3): begin
          span_r[0] <= span_r[3];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      last_r <= 1'b0;
    end else if (cmd.load) begin
      fill_r <= fill_r + FILL_W'(1);
      last_r <= in_data.text_end;
    end else if (cmd.step) begin
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.step && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step && emit) begin
      out_item_r.code_point  <= cp;
      out_item_r.final_point <= last_r && (fill_nxt == '0);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

endmodule

// File: design/u8dec_checker.sv
// ----------------------------------------------------------------------------
// u8dec_checker
// Port-level checks for the UTF-8 decoder, bound to the top level.
// ----------------------------------------------------------------------------
module u8dec_checker
  import u8dec_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  // a stalled result holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // every accepted byte gets a decode decision before the next byte is taken
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("byte accepted during decode");

  // reset empties the output register
  assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a result cannot appear the cycle a byte is taken from idle with no result
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !out_valid |=> !out_valid)
    else $error("result without a decode cycle");

endmodule

bind utf8_code_point_decoder u8dec_checker u_u8dec_checker (.*);
